// ----- sv/tec_pkg.sv -----
// types, codes and constants of the touch event calibrator
package tec_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_MUL,
        ST_WB,
        ST_CMP,
        ST_EMIT
    } state_t;

    typedef logic signed [19:0] pos_t;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_DOWN    = 2'd1;
    localparam logic [1:0] CMD_UP      = 2'd2;
    localparam logic [1:0] CMD_BUTTONS = 2'd3;

    localparam logic [1:0] KIND_MOVE    = 2'd0;
    localparam logic [1:0] KIND_RAW     = 2'd1;
    localparam logic [1:0] KIND_PRESS   = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN         = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_CROSS        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET       = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN         = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CROSS        = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_INTERVAL = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_ENABLE     = 8'd7;

    localparam logic [2:0] STEP_AX = 3'd0;
    localparam logic [2:0] STEP_BY = 3'd1;
    localparam logic [2:0] STEP_XC = 3'd2;
    localparam logic [2:0] STEP_X  = 3'd3;
    localparam logic [2:0] STEP_YC = 3'd4;
    localparam logic [2:0] STEP_Y  = 3'd5;

    localparam int X_MIN    = 'h1900;
    localparam int Y_MIN    = 'h2a00;
    localparam int X_RANGE  = 'hd700 - 'h1900;
    localparam int Y_RANGE  = 'hd700 - 'h2a00;
    localparam int DIV_BIAS = 16384;
    localparam int Q_ONE    = 65536;
    localparam int DEAD_BAND = 655;

    // x range is 95 << 9, y range is 173 << 8; reciprocals are ceil(2^31 / 95)
    // and ceil(2^33 / 173), exact over the shifted dividend range
    localparam logic [25:0] X_RECIP = 26'd22605092;
    localparam logic [25:0] Y_RECIP = 26'd49652802;

    // bias keeps the dividend positive so floor division is plain unsigned
    localparam logic [32:0] X_DIV_ADD =
        33'(X_RANGE / 2 + DIV_BIAS * X_RANGE - X_MIN * Q_ONE);
    localparam logic [32:0] Y_DIV_ADD =
        33'(Y_RANGE / 2 + DIV_BIAS * Y_RANGE - Y_MIN * Q_ONE);

    function automatic pos_t sat_pos(input logic signed [40:0] v);
        pos_t r;
        if (v > 41'sd524287)
            r = 20'sh7ffff;
        else if (v < -41'sd524288)
            r = 20'sh80000;
        else
            r = v[19:0];
        return r;
    endfunction

endpackage

// ----- sv/tec_if.sv -----
// handshake channels of the touch event calibrator
interface tec_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [47:0] timestamp;
    modport source (output valid, cmd, raw_x, raw_y, timestamp, input ready);
    modport sink (input valid, cmd, raw_x, raw_y, timestamp, output ready);
endinterface

interface tec_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic               pressed;
    logic [7:0]         clicks;
    logic [47:0]        stamp;
    logic               last;
    modport source (output valid, kind, pos_x, pos_y, pressed, clicks, stamp, last,
                    input ready);
    modport sink (input valid, kind, pos_x, pos_y, pressed, clicks, stamp, last,
                  output ready);
endinterface

interface tec_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/touch_event_calibrator.sv -----
// touch event calibrator top level
// A pen-down item is normalized by reciprocal multiplication (x in ST_DIV_X, y in
// ST_DIV_Y), then runs six products on one shared 20x20 multiplier, each through
// ST_MUL and ST_WB, then one dead-band compare in ST_CMP and one result per emit
// step in ST_EMIT, which holds while the result side stalls and returns to idle.
// A pen-up item goes from idle straight to ST_EMIT; none and button items stay in
// idle. The input is not ready while an item is at work; the last result may still
// wait in the output register while the next item is taken.
// Configuration is always ready.
module touch_event_calibrator
    import tec_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    tec_evt_if.sink evt,
    tec_res_if.source res,
    tec_cfg_if.sink cfg
);

    state_t state_reg, state_next;

    pos_t        x_offset_reg, x_gain_reg, x_cross_reg;
    pos_t        y_offset_reg, y_gain_reg, y_cross_reg;
    logic [23:0] click_interval_reg;
    logic        raw_enable_reg;

    pos_t        saved_x_reg, saved_y_reg, norm_x_reg, norm_y_reg;
    logic        pen_down_reg, reported_down_reg;
    logic [7:0]  click_count_reg;
    logic [47:0] last_press_time_reg;
    logic [47:0] stamp_reg;
    logic [15:0] raw_y_reg;

    logic [32:0] div_reg;

    logic [2:0]         step_reg;
    logic signed [39:0] prod_reg;
    pos_t               ax_reg, by_reg, t_reg, x_reg, y_reg;

    logic em_move_reg, em_raw_reg, em_pr_reg;
    logic out_valid_reg;

    logic        accept, slot_free, load_out, any_em;
    logic [32:0] div_x_init, div_y_init;
    logic [24:0] recip_n;
    logic [25:0] recip_m;
    logic [50:0] recip_p;
    logic [16:0] quot;
    pos_t        op_a, op_b, mul_r, plus_one;
    logic signed [40:0] rnd_sum;
    logic signed [20:0] dx, dy;
    logic        in_band;
    pos_t        fx, fy;
    logic        within_win;
    logic [7:0]  new_count;
    logic [1:0]  sel_kind;
    pos_t        sel_x, sel_y;
    logic        sel_pressed, sel_last;
    logic [7:0]  sel_clicks;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (evt.valid)
                begin
                    if (evt.cmd == CMD_DOWN)
                        state_next = ST_DIV_X;
                    else if (evt.cmd == CMD_UP)
                        state_next = ST_EMIT;
                end
            end
            ST_DIV_X: state_next = ST_DIV_Y;
            ST_DIV_Y: state_next = ST_MUL;
            ST_MUL:   state_next = ST_WB;
            ST_WB:    state_next = (step_reg == STEP_Y) ? ST_CMP : ST_MUL;
            ST_CMP:   state_next = ST_EMIT;
            ST_EMIT:  if (!any_em) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        evt.ready = (state_reg == ST_IDLE);
        cfg.ready = 1'b1;
        accept    = evt.valid && evt.ready;
        any_em    = em_move_reg || em_raw_reg || em_pr_reg;
        slot_free = !out_valid_reg || res.ready;
        load_out  = (state_reg == ST_EMIT) && slot_free && any_em;
    end

    // normalization by reciprocal multiplication
    always_comb
    begin
        div_x_init = {1'b0, evt.raw_x, 16'h0000} + X_DIV_ADD;
        div_y_init = {1'b0, raw_y_reg, 16'h0000} + Y_DIV_ADD;
        recip_n    = (state_reg == ST_DIV_X) ? {1'b0, div_reg[32:9]} : div_reg[32:8];
        recip_m    = (state_reg == ST_DIV_X) ? X_RECIP : Y_RECIP;
        recip_p    = recip_n * recip_m;
        quot       = (state_reg == ST_DIV_X) ? recip_p[47:31] : recip_p[49:33];
    end

    // multiplier operands and rounding
    always_comb
    begin
        case (step_reg)
            STEP_AX:
            begin
                op_a = sat_pos(41'(norm_x_reg) + 41'(x_offset_reg));
                op_b = x_gain_reg;
            end
            STEP_BY:
            begin
                op_a = sat_pos(41'(norm_y_reg) + 41'(y_offset_reg));
                op_b = y_gain_reg;
            end
            STEP_XC: begin op_a = by_reg; op_b = x_cross_reg; end
            STEP_X:  begin op_a = ax_reg; op_b = t_reg;       end
            STEP_YC: begin op_a = ax_reg; op_b = y_cross_reg; end
            STEP_Y:  begin op_a = by_reg; op_b = t_reg;       end
            default: begin op_a = '0;     op_b = '0;          end
        endcase
        rnd_sum  = 41'(prod_reg) + 41'sd32768;
        mul_r    = sat_pos(rnd_sum >>> 16);
        plus_one = sat_pos(41'(mul_r) + 41'(Q_ONE));
    end

    // dead band
    always_comb
    begin
        dx      = 21'(x_reg) - 21'(saved_x_reg);
        dy      = 21'(y_reg) - 21'(saved_y_reg);
        in_band = (dx > -21'sd655) && (dx < 21'sd655) &&
                  (dy > -21'sd655) && (dy < 21'sd655);
        fx      = in_band ? saved_x_reg : x_reg;
        fy      = in_band ? saved_y_reg : y_reg;
    end

    // result selection
    always_comb
    begin
        within_win = ({1'b0, last_press_time_reg} + 49'(click_interval_reg)) >
                     {1'b0, stamp_reg};
        if (!within_win)
            new_count = 8'd1;
        else if (click_count_reg == 8'hff)
            new_count = click_count_reg;
        else
            new_count = click_count_reg + 8'd1;

        sel_x       = '0;
        sel_y       = '0;
        sel_clicks  = '0;
        sel_pressed = reported_down_reg;
        if (em_move_reg)
        begin
            sel_kind = KIND_MOVE;
            sel_x    = saved_x_reg;
            sel_y    = saved_y_reg;
            sel_last = !(em_raw_reg || em_pr_reg);
        end
        else if (em_raw_reg)
        begin
            sel_kind = KIND_RAW;
            sel_x    = norm_x_reg;
            sel_y    = norm_y_reg;
            sel_last = !em_pr_reg;
        end
        else
        begin
            sel_kind    = pen_down_reg ? KIND_PRESS : KIND_RELEASE;
            sel_pressed = pen_down_reg;
            sel_clicks  = pen_down_reg ? new_count : 8'd0;
            sel_last    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            x_offset_reg        <= '0;
            x_gain_reg          <= 20'sh10000;
            x_cross_reg         <= '0;
            y_offset_reg        <= '0;
            y_gain_reg          <= 20'sh10000;
            y_cross_reg         <= '0;
            click_interval_reg  <= 24'd500000;
            raw_enable_reg      <= 1'b0;
            saved_x_reg         <= -20'sh10000;
            saved_y_reg         <= -20'sh10000;
            norm_x_reg          <= '0;
            norm_y_reg          <= '0;
            pen_down_reg        <= 1'b0;
            reported_down_reg   <= 1'b0;
            click_count_reg     <= '0;
            last_press_time_reg <= '0;
            em_move_reg         <= 1'b0;
            em_raw_reg          <= 1'b0;
            em_pr_reg           <= 1'b0;
            out_valid_reg       <= 1'b0;
            step_reg            <= STEP_AX;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_X_OFFSET:       x_offset_reg       <= cfg.data[19:0];
                    REG_X_GAIN:         x_gain_reg         <= cfg.data[19:0];
                    REG_X_CROSS:        x_cross_reg        <= cfg.data[19:0];
                    REG_Y_OFFSET:       y_offset_reg       <= cfg.data[19:0];
                    REG_Y_GAIN:         y_gain_reg         <= cfg.data[19:0];
                    REG_Y_CROSS:        y_cross_reg        <= cfg.data[19:0];
                    REG_CLICK_INTERVAL: click_interval_reg <= cfg.data;
                    REG_RAW_ENABLE:     raw_enable_reg     <= cfg.data[0];
                    default:            ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && evt.cmd == CMD_DOWN)
                    begin
                        pen_down_reg <= 1'b1;
                    end
                    else if (accept && evt.cmd == CMD_UP)
                    begin
                        pen_down_reg <= 1'b0;
                        em_move_reg  <= 1'b0;
                        em_raw_reg   <= 1'b0;
                        em_pr_reg    <= reported_down_reg;
                    end
                end
                ST_DIV_X:
                begin
                    norm_x_reg <= 20'(quot) - 20'(DIV_BIAS);
                end
                ST_DIV_Y:
                begin
                    norm_y_reg <= 20'(quot) - 20'(DIV_BIAS);
                    step_reg   <= STEP_AX;
                end
                ST_WB:
                begin
                    if (step_reg != STEP_Y)
                        step_reg <= step_reg + 3'd1;
                end
                ST_CMP:
                begin
                    saved_x_reg <= fx;
                    saved_y_reg <= fy;
                    em_move_reg <= (fx != saved_x_reg) || (fy != saved_y_reg);
                    em_raw_reg  <= raw_enable_reg &&
                                   ((fx != saved_x_reg) || (fy != saved_y_reg) ||
                                    !reported_down_reg);
                    em_pr_reg   <= !reported_down_reg;
                end
                ST_EMIT:
                begin
                    if (load_out)
                    begin
                        if (em_move_reg)
                            em_move_reg <= 1'b0;
                        else if (em_raw_reg)
                            em_raw_reg <= 1'b0;
                        else
                        begin
                            em_pr_reg         <= 1'b0;
                            reported_down_reg <= pen_down_reg;
                            if (pen_down_reg)
                            begin
                                click_count_reg     <= new_count;
                                last_press_time_reg <= stamp_reg;
                            end
                        end
                    end
                end
                default: ;
            endcase

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stamp_reg <= evt.timestamp;
            raw_y_reg <= evt.raw_y;
            div_reg   <= div_x_init;
        end
        if (state_reg == ST_DIV_X)
            div_reg <= div_y_init;
        if (state_reg == ST_MUL)
            prod_reg <= op_a * op_b;
        if (state_reg == ST_WB)
        begin
            case (step_reg)
                STEP_AX: ax_reg <= mul_r;
                STEP_BY: by_reg <= mul_r;
                STEP_XC: t_reg  <= plus_one;
                STEP_X:  x_reg  <= mul_r;
                STEP_YC: t_reg  <= plus_one;
                STEP_Y:  y_reg  <= mul_r;
                default: ;
            endcase
        end
        if (load_out)
        begin
            res.kind    <= sel_kind;
            res.pos_x   <= sel_x;
            res.pos_y   <= sel_y;
            res.pressed <= sel_pressed;
            res.clicks  <= sel_clicks;
            res.stamp   <= stamp_reg;
            res.last    <= sel_last;
        end
    end

    assign res.valid = out_valid_reg;

    // reported state catches up with the pen before the next item
    a_idle_synced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (pen_down_reg == reported_down_reg))
        else $error("pen state not reported at idle");

    a_mul_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB && step_reg == STEP_Y) |=> (state_reg == ST_CMP))
        else $error("product sequence did not end in compare");

    a_press_clicks: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.kind == KIND_PRESS) |-> (res.clicks != 8'd0 && res.pressed))
        else $error("press without click count");

endmodule

// ----- tb/tec_checker.sv -----
// result checker of the touch event calibrator: predicts every item and compares
`timescale 1ns / 100ps

module tec_checker
    import tec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tec_evt_if        evt,
    tec_res_if        res,
    tec_cfg_if        cfg,
    output int        errors,
    output int        pending
);

    localparam longint PANEL_X0   = 'h1900;
    localparam longint PANEL_Y0   = 'h2a00;
    localparam longint SPAN_X     = 'hd700 - 'h1900;
    localparam longint SPAN_Y     = 'hd700 - 'h2a00;
    localparam longint UNITY      = 65536;
    localparam longint JITTER_LIM = 655;

    typedef struct {
        logic [1:0]  kind;
        pos_t        px;
        pos_t        py;
        logic        pressed;
        logic [7:0]  clicks;
        logic [47:0] stamp;
        logic        last;
    } touch_result_t;

    touch_result_t touch_results_q[$];

    pos_t        cal_x_offset, cal_x_gain, cal_x_cross;
    pos_t        cal_y_offset, cal_y_gain, cal_y_cross;
    logic [23:0] cal_click_window;
    logic        cal_raw_mode;

    longint      pos_saved_x, pos_saved_y, pos_norm_x, pos_norm_y;
    bit          pen_is_down, shown_down;
    int unsigned click_cnt;
    logic [47:0] press_time;

    function automatic longint clamp20(input longint v);
        if (v > 524287)
            return 524287;
        if (v < -524288)
            return -524288;
        return v;
    endfunction

    function automatic longint floor_div(input longint n, input longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        return clamp20(floor_div(a * b + 32768, 65536));
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic predict_touch(input logic [1:0] cmd, input logic [15:0] rx,
                                 input logic [15:0] ry, input logic [47:0] ts);
        touch_result_t buf_r[3];
        int            n;
        bit            moved;
        bit            prev;
        longint        ax, by, x, y, dx, dy;
        n = 0;
        moved = 0;
        prev = shown_down;
        if (cmd == CMD_UP)
            pen_is_down = 0;
        else if (cmd == CMD_DOWN)
        begin
            pen_is_down = 1;
            pos_norm_x = clamp20(floor_div((longint'(rx) - PANEL_X0) * UNITY + SPAN_X / 2,
                                           SPAN_X));
            pos_norm_y = clamp20(floor_div((longint'(ry) - PANEL_Y0) * UNITY + SPAN_Y / 2,
                                           SPAN_Y));
            ax = q_mul(clamp20(pos_norm_x + longint'(cal_x_offset)), longint'(cal_x_gain));
            by = q_mul(clamp20(pos_norm_y + longint'(cal_y_offset)), longint'(cal_y_gain));
            x = q_mul(ax, clamp20(UNITY + q_mul(by, longint'(cal_x_cross))));
            y = q_mul(by, clamp20(UNITY + q_mul(ax, longint'(cal_y_cross))));
            dx = x - pos_saved_x;
            dy = y - pos_saved_y;
            if (dx > -JITTER_LIM && dx < JITTER_LIM && dy > -JITTER_LIM && dy < JITTER_LIM)
            begin
                x = pos_saved_x;
                y = pos_saved_y;
            end
            if (x != pos_saved_x || y != pos_saved_y)
            begin
                moved = 1;
                pos_saved_x = x;
                pos_saved_y = y;
            end
        end
        if (moved)
        begin
            buf_r[n] = '{KIND_MOVE, pos_t'(pos_saved_x), pos_t'(pos_saved_y), prev, 8'd0, ts, 1'b0};
            n++;
        end
        if (pen_is_down && cal_raw_mode && (moved || pen_is_down != shown_down))
        begin
            buf_r[n] = '{KIND_RAW, pos_t'(pos_norm_x), pos_t'(pos_norm_y), prev, 8'd0, ts, 1'b0};
            n++;
        end
        if (pen_is_down != shown_down)
        begin
            if (pen_is_down)
            begin
                if (64'(press_time) + 64'(cal_click_window) > 64'(ts))
                begin
                    if (click_cnt < 255)
                        click_cnt++;
                end
                else
                    click_cnt = 1;
                press_time = ts;
            end
            buf_r[n] = '{pen_is_down ? KIND_PRESS : KIND_RELEASE, pos_t'(0), pos_t'(0),
                         pen_is_down, pen_is_down ? 8'(click_cnt) : 8'd0, ts, 1'b0};
            n++;
            shown_down = pen_is_down;
        end
        for (int i = 0; i < n; i++)
        begin
            buf_r[i].last = (i == n - 1);
            touch_results_q.push_back(buf_r[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        touch_result_t want;
        if (!rst_n)
        begin
            cal_x_offset = '0;
            cal_x_gain = pos_t'(UNITY);
            cal_x_cross = '0;
            cal_y_offset = '0;
            cal_y_gain = pos_t'(UNITY);
            cal_y_cross = '0;
            cal_click_window = 24'd500000;
            cal_raw_mode = 1'b0;
            pos_saved_x = -UNITY;
            pos_saved_y = -UNITY;
            pos_norm_x = 0;
            pos_norm_y = 0;
            pen_is_down = 0;
            shown_down = 0;
            click_cnt = 0;
            press_time = '0;
            touch_results_q.delete();
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (touch_results_q.size() == 0)
                    report("unexpected item, kind", res.kind, -1);
                else
                begin
                    want = touch_results_q.pop_front();
                    if (res.kind !== want.kind)
                        report("kind", res.kind, want.kind);
                    if (res.pos_x !== want.px)
                        report("pos_x", res.pos_x, want.px);
                    if (res.pos_y !== want.py)
                        report("pos_y", res.pos_y, want.py);
                    if (res.pressed !== want.pressed)
                        report("pressed", res.pressed, want.pressed);
                    if (res.clicks !== want.clicks)
                        report("clicks", res.clicks, want.clicks);
                    if (res.stamp !== want.stamp)
                        report("stamp", res.stamp, want.stamp);
                    if (res.last !== want.last)
                        report("last", res.last, want.last);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_X_OFFSET:       cal_x_offset = cfg.data[19:0];
                    REG_X_GAIN:         cal_x_gain = cfg.data[19:0];
                    REG_X_CROSS:        cal_x_cross = cfg.data[19:0];
                    REG_Y_OFFSET:       cal_y_offset = cfg.data[19:0];
                    REG_Y_GAIN:         cal_y_gain = cfg.data[19:0];
                    REG_Y_CROSS:        cal_y_cross = cfg.data[19:0];
                    REG_CLICK_INTERVAL: cal_click_window = cfg.data;
                    REG_RAW_ENABLE:     cal_raw_mode = cfg.data[0];
                    default:            ;
                endcase
            end
            if (evt.valid && evt.ready)
                predict_touch(evt.cmd, evt.raw_x, evt.raw_y, evt.timestamp);
        end
        pending = touch_results_q.size();
    end

    initial
    begin
        errors = 0;
        pending = 0;
    end

endmodule

// ----- tb/touch_event_calibrator_tb.sv -----
// stimulus and verdict for the touch event calibrator
`timescale 1ns / 100ps

module touch_event_calibrator_tb;
    import tec_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 64;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_cycles;
    int   stall_left;
    bit   steady;
    logic [47:0] now_us;
    logic [15:0] last_rx, last_ry;

    tec_evt_if evt_ch ();
    tec_res_if res_ch ();
    tec_cfg_if cfg_ch ();

    touch_event_calibrator uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    tec_checker chk
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_ch),
        .res     (res_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ch.ready = 1'b0;
            stall_left--;
        end
        else
        begin
            res_ch.ready = 1'b1;
            if (!steady && $urandom_range(0, 2) == 0)
                stall_left = gap_len();
        end
    end

    always @(posedge clk)
    begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_touch(input logic [1:0] cmd, input logic [15:0] rx,
                              input logic [15:0] ry, input logic [47:0] ts);
        int gap;
        evt_ch.valid = 1'b1;
        evt_ch.cmd = cmd;
        evt_ch.raw_x = rx;
        evt_ch.raw_y = ry;
        evt_ch.timestamp = ts;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        @(negedge clk);
        gap = steady ? 0 : gap_len();
        if (gap > 0)
        begin
            evt_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        evt_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_all(input logic [23:0] xo, input logic [23:0] xg,
                             input logic [23:0] xc, input logic [23:0] yo,
                             input logic [23:0] yg, input logic [23:0] yc,
                             input logic [23:0] window, input logic [23:0] raw);
        write_reg(REG_X_OFFSET, xo);
        write_reg(REG_X_GAIN, xg);
        write_reg(REG_X_CROSS, xc);
        write_reg(REG_Y_OFFSET, yo);
        write_reg(REG_Y_GAIN, yg);
        write_reg(REG_Y_CROSS, yc);
        write_reg(REG_CLICK_INTERVAL, window);
        write_reg(REG_RAW_ENABLE, raw);
    endtask

    function automatic logic [15:0] pick_raw(input logic [15:0] prior, input int lo,
                                             input int hi);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hffff;
        if (r < 5)
            return 16'($urandom);
        if (r < 8)
            return prior;
        if (r < 10)
            return prior + 16'($urandom_range(0, 4)) - 16'd2;
        return 16'($urandom_range(lo, hi));
    endfunction

    task automatic touch_down_rand(input int step_max);
        last_rx = pick_raw(last_rx, 'h1900, 'hd700);
        last_ry = pick_raw(last_ry, 'h2a00, 'hd700);
        now_us = now_us + 48'($urandom_range(1, step_max));
        send_touch(CMD_DOWN, last_rx, last_ry, now_us);
    endtask

    task automatic random_run(input int count, input int step_max, input bit pairs);
        int r;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                drain();
            if (i % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 3)
                send_touch(CMD_NONE, 16'($urandom), 16'($urandom),
                           48'({$urandom, $urandom}));
            else if (r < 6)
                send_touch(CMD_BUTTONS, 16'($urandom), 16'($urandom), now_us);
            else if (r < 8)
            begin
                now_us = 48'({$urandom, $urandom});
                send_touch(CMD_DOWN, 16'($urandom), 16'($urandom), now_us);
            end
            else if (pairs)
            begin
                touch_down_rand(step_max);
                if ($urandom_range(0, 3) == 0)
                    touch_down_rand(step_max);
                now_us = now_us + 48'($urandom_range(1, step_max));
                send_touch(CMD_UP, 16'($urandom), 16'($urandom), now_us);
            end
            else if (r < 70)
                touch_down_rand(step_max);
            else
            begin
                now_us = now_us + 48'($urandom_range(1, step_max));
                send_touch(CMD_UP, 16'($urandom), 16'($urandom), now_us);
            end
        end
        steady = 0;
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        steady = 0;
        stall_left = 0;
        idle_cycles = 0;
        now_us = 48'd1000;
        last_rx = 16'h8000;
        last_ry = 16'h8000;
        res_ch.ready = 1'b0;
        evt_ch.valid = 1'b0;
        evt_ch.cmd = CMD_NONE;
        evt_ch.raw_x = '0;
        evt_ch.raw_y = '0;
        evt_ch.timestamp = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);

        // directed items under reset calibration
        send_touch(CMD_NONE, 16'hffff, 16'hffff, 48'hffff_ffff_ffff);
        send_touch(CMD_BUTTONS, 16'h0000, 16'h0000, 48'd0);
        send_touch(CMD_UP, 16'h1234, 16'h4321, 48'd50);
        send_touch(CMD_DOWN, 16'h1900, 16'h2a00, 48'd100);
        send_touch(CMD_DOWN, 16'h1900, 16'h2a00, 48'd200);
        send_touch(CMD_DOWN, 16'h1901, 16'h2a01, 48'd300);
        send_touch(CMD_DOWN, 16'h0000, 16'h0000, 48'd400);
        send_touch(CMD_DOWN, 16'hffff, 16'hffff, 48'd500);
        send_touch(CMD_UP, 16'h0000, 16'h0000, 48'd600);
        send_touch(CMD_DOWN, 16'h8000, 16'h7fff, 48'd700);
        send_touch(CMD_BUTTONS, 16'hffff, 16'hffff, 48'd750);
        send_touch(CMD_UP, 16'h8000, 16'h7fff, 48'd800);
        send_touch(CMD_DOWN, 16'hd700, 16'hd700, 48'd2000000);
        send_touch(CMD_NONE, 16'h5555, 16'haaaa, 48'd2000001);
        send_touch(CMD_UP, 16'haaaa, 16'h5555, 48'd2000002);
        send_touch(CMD_DOWN, 16'h7fff, 16'h8000, 48'hffff_ffff_ffff);
        send_touch(CMD_UP, 16'hffff, 16'h0000, 48'hffff_ffff_ffff);
        send_touch(CMD_DOWN, 16'h0000, 16'hffff, 48'd0);
        send_touch(CMD_UP, 16'h0000, 16'h0000, 48'd1);
        drain();

        // extreme calibration, zero click window, raw results on
        write_all(24'h080000, 24'h07ffff, 24'h07ffff, 24'h07ffff,
                  24'h080000, 24'h080000, 24'd0, 24'd1);
        now_us = 48'd10;
        random_run(60, 1000, 0);

        // mild calibration, widest window: click count climbs over many presses
        write_all(24'($urandom_range(0, 4000)), 24'h010000 + 24'($urandom_range(0, 8000)),
                  24'($urandom_range(0, 2000)), 24'hfff000, 24'h00f000,
                  24'hfff800, 24'hffffff, 24'd1);
        now_us = 48'd0;
        random_run(90, 200, 1);

        // arbitrary register contents, including an index past the list
        write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom), 24'($urandom_range(1, 400000)), 24'hfffffe);
        write_reg(REG_RAW_ENABLE + 8'd1, 24'($urandom));
        write_reg(8'hff, 24'hffffff);
        random_run(100, 300000, 0);

        // back to reset-like values, raw on
        write_all(24'd0, 24'h010000, 24'd0, 24'd0, 24'h010000, 24'd0, 24'd500000, 24'd1);
        random_run(80, 700000, 0);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
